[hdl/linear_interp_resampler_unit_macros.svh]
// Assertion macros shared by the resampler checker
`ifndef LINEAR_INTERP_RESAMPLER_UNIT_MACROS_SVH
`define LINEAR_INTERP_RESAMPLER_UNIT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted
`define LIRS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is asserted
`define LIRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/lirs_pkg.sv]
// Shared constants for the linear interpolation resampler
package lirs_pkg;

    // Phase accumulator and increment register width (unsigned fixed point)
    localparam int unsigned PHASE_W = 32;

endpackage

[hdl/lirs_sample_if.sv]
// Valid/ready channel carrying one input sample per request
interface lirs_sample_if #(
    parameter int SAMPLE_WIDTH = 24
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] in_sample;

    modport source (output valid, output in_sample, input ready);
    modport sink   (input valid, input in_sample, output ready);
endinterface

[hdl/lirs_result_if.sv]
// Valid/ready channel carrying one interpolated sample per request
interface lirs_result_if #(
    parameter int SAMPLE_WIDTH = 24
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] out_sample;
    logic                           last_of_run;

    modport source (output valid, output out_sample, output last_of_run, input ready);
    modport sink   (input valid, input out_sample, input last_of_run, output ready);
endinterface

[hdl/lirs_mac.sv]
// Shared multiply-round-add unit: base + round((diff * frac) / 2^FRAC_BITS)
module lirs_mac #(
    parameter int SAMPLE_WIDTH = 24,
    parameter int FRAC_BITS    = 24
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           load,
    input  logic signed [SAMPLE_WIDTH:0]   diff,
    input  logic        [FRAC_BITS-1:0]    frac,
    input  logic signed [SAMPLE_WIDTH-1:0] base,
    output logic signed [SAMPLE_WIDTH-1:0] result
);

    localparam int PW = SAMPLE_WIDTH + FRAC_BITS + 2;
    localparam int QW = PW - FRAC_BITS;
    localparam logic [PW-1:0] ROUND_HALF =
        {{(PW - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};

    logic signed [PW-1:0] prod_reg;
    logic signed [PW-1:0] prod_next;
    logic signed [PW-1:0] rounded;
    logic signed [QW-1:0] quot;
    logic signed [QW-1:0] sum;

    // Product stage: signed difference times unsigned fraction
    assign prod_next = PW'(diff) * PW'($signed({1'b0, frac}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_reg <= '0;
        end
        else if (load)
        begin
            prod_reg <= prod_next;
        end
    end

    // Round half up, floor shift, then add the base sample
    assign rounded = prod_reg + $signed(ROUND_HALF);
    assign quot    = rounded[PW-1:FRAC_BITS];
    assign sum     = QW'(base) + quot;
    assign result  = sum[SAMPLE_WIDTH-1:0];

endmodule

[hdl/linear_interp_resampler_unit.sv]
// Linear interpolation resampler: one sample in, zero to MAX_OUTPUTS results out.
// An input request is taken in the idle state; each result then goes through the
// multiply, round-and-add and present states, holding in the last until the output
// side takes it; one shared multiplier serves all results. An item that only
// consumes phase yields no result. With an increment of exactly one the sample
// passes through as a single result, from idle straight to the present state.
// The block takes no new sample until the last result of the current one has been
// taken. phase_increment is unsigned with FRAC_BITS fraction bits; the user must
// write it through cfg_we / cfg_wdata only while idle, as the block does not check.
module linear_interp_resampler_unit
    import lirs_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 24,
    parameter int FRAC_BITS    = 24,
    parameter int MAX_OUTPUTS  = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [PHASE_W-1:0] cfg_wdata,
    lirs_sample_if.sink        sample_ch,
    lirs_result_if.source      result_ch
);

    localparam int CW = $clog2(MAX_OUTPUTS);
    localparam logic [PHASE_W:0]   PHASE_ONE  = (PHASE_W + 1)'(1) << FRAC_BITS;
    localparam logic [PHASE_W-1:0] INC_RESET  = PHASE_ONE[PHASE_W-1:0];
    localparam logic [CW-1:0]      COUNT_LAST = CW'(MAX_OUTPUTS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_ROUND,
        S_OUT
    } state_t;

    state_t                         state_reg;
    logic        [PHASE_W-1:0]      inc_reg;
    logic        [PHASE_W-1:0]      phase_reg;
    logic signed [SAMPLE_WIDTH-1:0] prev_reg;
    logic signed [SAMPLE_WIDTH-1:0] x_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_sample_reg;
    logic                           out_last_reg;
    logic        [CW-1:0]           count_reg;

    logic signed [SAMPLE_WIDTH:0]   diff;
    logic signed [SAMPLE_WIDTH-1:0] mac_result;
    logic        [PHASE_W:0]        phase_sum;
    logic                           phase_wrap;
    logic        [PHASE_W:0]        phase_wrapped;
    logic        [PHASE_W-1:0]      phase_adv_next;
    logic        [PHASE_W:0]        phase_dec;
    logic                           last_next;
    logic                           unity;
    logic                           phase_ge_one;

    // Handshake outputs follow the sequencer state
    assign sample_ch.ready       = (state_reg == S_IDLE);
    assign result_ch.valid       = (state_reg == S_OUT);
    assign result_ch.out_sample  = out_sample_reg;
    assign result_ch.last_of_run = out_last_reg;

    // Entry decisions
    assign unity        = (inc_reg == INC_RESET);
    assign phase_ge_one = ({1'b0, phase_reg} >= PHASE_ONE);
    assign phase_dec    = {1'b0, phase_reg} - PHASE_ONE;

    // Phase advance after each result
    assign phase_sum      = {1'b0, phase_reg} + {1'b0, inc_reg};
    assign phase_wrap     = (phase_sum >= PHASE_ONE);
    assign phase_wrapped  = phase_sum - PHASE_ONE;
    assign phase_adv_next = phase_wrap ? phase_wrapped[PHASE_W-1:0]
                                       : phase_sum[PHASE_W-1:0];
    assign last_next      = phase_wrap || (count_reg == COUNT_LAST);

    // Interpolation operands
    assign diff = (SAMPLE_WIDTH + 1)'(x_reg) - (SAMPLE_WIDTH + 1)'(prev_reg);

    lirs_mac #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .FRAC_BITS    (FRAC_BITS)
    ) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (state_reg == S_MUL),
        .diff   (diff),
        .frac   (phase_reg[FRAC_BITS-1:0]),
        .base   (prev_reg),
        .result (mac_result)
    );

    // Sequencer and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            inc_reg        <= INC_RESET;
            phase_reg      <= '0;
            prev_reg       <= '0;
            x_reg          <= '0;
            out_sample_reg <= '0;
            out_last_reg   <= 1'b0;
            count_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                inc_reg <= cfg_wdata;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (sample_ch.valid)
                    begin
                        x_reg <= sample_ch.in_sample;
                        priority if (unity)
                        begin
                            // pass-through
                            out_sample_reg <= sample_ch.in_sample;
                            out_last_reg   <= 1'b1;
                            prev_reg       <= sample_ch.in_sample;
                            state_reg      <= S_OUT;
                        end
                        else if (phase_ge_one)
                        begin
                            // downsampling: sample only consumes phase
                            phase_reg <= phase_dec[PHASE_W-1:0];
                            prev_reg  <= sample_ch.in_sample;
                        end
                        else
                        begin
                            count_reg <= '0;
                            state_reg <= S_MUL;
                        end
                    end
                end

                S_MUL:
                begin
                    state_reg <= S_ROUND;
                end

                S_ROUND:
                begin
                    out_sample_reg <= mac_result;
                    out_last_reg   <= last_next;
                    phase_reg      <= phase_adv_next;
                    count_reg      <= count_reg + 1'b1;
                    if (last_next)
                    begin
                        prev_reg <= x_reg;
                    end
                    state_reg <= S_OUT;
                end

                S_OUT:
                begin
                    if (result_ch.ready)
                    begin
                        state_reg <= out_last_reg ? S_IDLE : S_MUL;
                    end
                end
            endcase
        end
    end

endmodule

[hdl/lirs_checker.sv]
// Port-level checks on the resampler, bound to the top level
`include "linear_interp_resampler_unit_macros.svh"

module lirs_checker #(
    parameter int SAMPLE_WIDTH = 24
) (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic [SAMPLE_WIDTH-1:0] out_sample,
    input logic                    out_last
);

    logic in_acc;
    logic out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // A pending result stays offered
    `LIRS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")
    // A stalled result keeps its payload
    `LIRS_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_sample) && $stable(out_last), "stalled result changed")
    // One item at a time: no new sample while a result is offered
    `LIRS_ASSERT_NOW(a_excl, clk, rst_n, in_ready, !out_valid, "sample taken while a result is pending")
    // Taking the last result frees the block for the next sample
    `LIRS_ASSERT_NEXT(a_last_frees, clk, rst_n, out_acc && out_last, in_ready, "block not ready after last result")
    // A result that is not the last keeps the block busy
    `LIRS_ASSERT_NEXT(a_run_busy, clk, rst_n, out_acc && !out_last, !in_ready && !in_acc, "block ready in the middle of a run")

endmodule

bind linear_interp_resampler_unit lirs_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_lirs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (sample_ch.valid),
    .in_ready   (sample_ch.ready),
    .out_valid  (result_ch.valid),
    .out_ready  (result_ch.ready),
    .out_sample (result_ch.out_sample),
    .out_last   (result_ch.last_of_run)
);

[sim/tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for the linear interpolation resampler unit
module tb;
    import lirs_pkg::*;

    localparam int SW      = 24;
    localparam int FRAC    = 24;
    localparam int MAX_RUN = 64;

    localparam logic [63:0] UNITY   = 64'd1 << FRAC;
    localparam logic [31:0] INC_MIN = 32'd262144;
    localparam logic [31:0] INC_MAX = 32'hFFFF_FFFF;

    localparam int RANDOM_ITEMS = 450;
    localparam int IDLE_PCT     = 12;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 8;
    localparam int TAIL_CYCLES  = 3 * MAX_RUN + 16;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int REPORT_CAP   = 40;

    typedef enum int
    {
        RATE_FINE_UP,
        RATE_UP,
        RATE_DOWN,
        RATE_NEAR_UNITY,
        RATE_UNITY
    } rate_mode_t;

    typedef struct
    {
        logic signed [SW-1:0] smp;
        logic                 last;
    } interp_out_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [PHASE_W-1:0] cfg_wdata = '0;

    lirs_sample_if #(.SAMPLE_WIDTH(SW)) sample_ch ();
    lirs_result_if #(.SAMPLE_WIDTH(SW)) result_ch ();

    linear_interp_resampler_unit #(
        .SAMPLE_WIDTH(SW),
        .FRAC_BITS   (FRAC),
        .MAX_OUTPUTS (MAX_RUN)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .sample_ch(sample_ch.sink),
        .result_ch(result_ch.source)
    );

    // Predictor state: increment register, phase accumulator, held sample
    logic [31:0]          step_inc;
    logic [63:0]          phase_acc;
    logic signed [SW-1:0] held_sample;

    interp_out_t          interp_due_q[$];
    logic signed [SW-1:0] sample_feed_q[$];
    interp_out_t          due_head;

    int     mismatches          = 0;
    int     outputs_checked     = 0;
    int     requests_taken      = 0;
    int     phase_only_requests = 0;
    int     cfg_writes          = 0;
    int     random_items        = 0;
    longint cycle_count         = 0;

    logic                 req_done   = 1'b0;
    logic                 jitter_on  = 1'b1;
    logic                 hold_ask   = 1'b0;
    int                   hold_left  = 0;
    logic signed [SW-1:0] walk_level = '0;

    always #5 clk = ~clk;

    // Expected results for one accepted request
    function automatic void interpolate_input(input logic signed [SW-1:0] smp);
        interp_out_t        r;
        logic signed [63:0] diff;
        logic signed [63:0] term;
        logic signed [63:0] quot;
        logic signed [63:0] sum;
        logic [63:0]        nxt;
        int                 n;
        logic               done;
        // straight pass-through at unity rate, phase untouched
        if (step_inc == UNITY[31:0])
        begin
            r.smp  = smp;
            r.last = 1'b1;
            interp_due_q.push_back(r);
            held_sample = smp;
            return;
        end
        // phase still at or past one: request only consumes phase
        if (phase_acc >= UNITY)
        begin
            phase_acc   = phase_acc - UNITY;
            held_sample = smp;
            phase_only_requests++;
            return;
        end
        n    = 0;
        done = 1'b0;
        while (!done)
        begin
            diff  = 64'(signed'(smp)) - 64'(signed'(held_sample));
            term  = diff * $signed({1'b0, phase_acc[62:0]}) + $signed(UNITY >> 1);
            quot  = term >>> FRAC;
            sum   = 64'(signed'(held_sample)) + quot;
            r.smp = sum[SW-1:0];
            n++;
            nxt = phase_acc + {32'd0, step_inc};
            if (nxt >= UNITY)
            begin
                phase_acc = nxt - UNITY;
                done      = 1'b1;
            end
            else
            begin
                phase_acc = nxt;
                // output cap: stop while the phase is still below one
                if (n >= MAX_RUN)
                    done = 1'b1;
            end
            r.last = done;
            interp_due_q.push_back(r);
        end
        held_sample = smp;
    endfunction

    // Sample content: full-scale extremes, a slow walk, or uniform noise
    function automatic logic signed [SW-1:0] random_sample();
        logic [31:0] r;
        r = $urandom();
        case ($urandom_range(0, 9))
            0: return {1'b0, {(SW-1){1'b1}}};
            1: return {1'b1, {(SW-1){1'b0}}};
            2, 3:
            begin
                walk_level = walk_level + SW'(int'($urandom_range(0, 4096)) - 2048);
                return walk_level;
            end
            default: return r[SW-1:0];
        endcase
    endfunction

    task automatic feed(input logic signed [SW-1:0] v);
        sample_feed_q.push_back(v);
    endtask

    // Sender paused until every expected result has come, then a short drain
    task automatic wait_quiet();
        do
            @(posedge clk);
        while (sample_feed_q.size() != 0 || sample_ch.valid || interp_due_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic load_increment(input logic [31:0] inc);
        wait_quiet();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= inc;
        @(negedge clk);
        cfg_we    <= 1'b0;
        step_inc  = inc;
        cfg_writes++;
    endtask

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d results still due", $time,
                     interp_due_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Accepted input requests feed the predictor
    always @(posedge clk)
    begin
        if (rst_n && sample_ch.valid && sample_ch.ready)
        begin
            interpolate_input(sample_ch.in_sample);
            requests_taken++;
            req_done = 1'b1;
        end
    end

    // Sample driver: holds a request until taken, idles at random
    always @(negedge clk)
    begin
        if (!rst_n)
            sample_ch.valid <= 1'b0;
        else if (!sample_ch.valid || req_done)
        begin
            req_done = 1'b0;
            if (sample_feed_q.size() != 0 &&
                !(jitter_on && $urandom_range(0, 99) < IDLE_PCT))
            begin
                sample_ch.in_sample <= sample_feed_q.pop_front();
                sample_ch.valid     <= 1'b1;
            end
            else
                sample_ch.valid <= 1'b0;
        end
    end

    // Result side ready: random stalls plus one long hold-off on request
    always @(negedge clk)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else if (hold_left != 0)
        begin
            hold_left--;
            result_ch.ready <= 1'b0;
        end
        else if (hold_ask)
        begin
            hold_ask  = 1'b0;
            hold_left = HOLD_CYCLES;
            result_ch.ready <= 1'b0;
        end
        else
            result_ch.ready <= !(jitter_on && $urandom_range(0, 99) < IDLE_PCT);
    end

    // Result monitor: compare against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (interp_due_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_CAP)
                    $display("%0t: unexpected result, expected none, actual sample %0d last %0b",
                             $time, result_ch.out_sample, result_ch.last_of_run);
            end
            else
            begin
                due_head = interp_due_q.pop_front();
                outputs_checked++;
                if (result_ch.out_sample !== due_head.smp ||
                    result_ch.last_of_run !== due_head.last)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_CAP)
                        $display("%0t: expected sample %0d last %0b, actual sample %0d last %0b",
                                 $time, due_head.smp, due_head.last,
                                 result_ch.out_sample, result_ch.last_of_run);
                end
            end
        end
    end

    // Stimulus sequence
    initial
    begin
        rate_mode_t  mode;
        logic [31:0] inc;
        logic [31:0] nudge;
        int          count;
        int          catch_up;
        int          phase_no;
        sample_ch.valid     = 1'b0;
        sample_ch.in_sample = '0;
        result_ch.ready     = 1'b0;
        step_inc    = UNITY[31:0];
        phase_acc   = '0;
        held_sample = '0;
        phase_no    = 0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // pass-through at the reset increment, field extremes
        feed(24'sh7F_FFFF);
        feed(-24'sh80_0000);
        feed(24'sh00_0000);
        feed(-24'sh00_0001);
        feed(24'sh00_0001);

        // quarter step, full-scale swings both ways
        load_increment(32'h0040_0000);
        feed(-24'sh80_0000);
        feed(24'sh7F_FFFF);
        feed(24'sh7F_FFFF);
        feed(-24'sh80_0000);

        // threefold downsampling: requests that only consume phase
        load_increment(32'h0300_0000);
        repeat (6) feed(random_sample());

        // step below 1/64: output cap reached
        load_increment(32'h0002_0000);
        repeat (3) feed(random_sample());

        // smallest legal step
        load_increment(INC_MIN);
        repeat (2) feed(random_sample());

        // random rate phases
        while (random_items < RANDOM_ITEMS)
        begin
            mode = rate_mode_t'($urandom_range(0, 4));
            if (phase_no == 2)
                mode = RATE_FINE_UP;
            case (mode)
                RATE_FINE_UP:
                begin
                    inc   = $urandom_range(INC_MIN, 32'h0010_0000);
                    count = $urandom_range(4, 10);
                end
                RATE_UP:
                begin
                    inc   = $urandom_range(32'h0010_0001, 32'h00FF_FFFF);
                    count = $urandom_range(15, 35);
                end
                RATE_DOWN:
                begin
                    inc   = $urandom_range(32'h0100_0001, 32'h0800_0000);
                    count = $urandom_range(20, 50);
                end
                RATE_NEAR_UNITY:
                begin
                    nudge = $urandom_range(1, 255);
                    inc   = $urandom_range(0, 1) ? UNITY[31:0] + nudge : UNITY[31:0] - nudge;
                    count = $urandom_range(15, 35);
                end
                default:
                begin
                    inc   = UNITY[31:0];
                    count = $urandom_range(10, 25);
                end
            endcase
            // largest increment once: one result, then a long phase debt
            if (phase_no == 6)
            begin
                inc   = INC_MAX;
                count = 10;
            end
            // a long stretch with no idling on either side
            jitter_on = !(phase_no == 4 || phase_no == 5);
            load_increment(inc);

            // pay off any phase debt left by heavy downsampling
            catch_up = int'(phase_acc >> FRAC);
            if (step_inc != UNITY[31:0])
            begin
                repeat (catch_up) feed(random_sample());
                random_items += catch_up;
            end

            // receiver holds off while requests keep coming
            if (phase_no == 2)
            begin
                @(posedge clk);
                hold_ask = 1'b1;
            end

            repeat (count) feed(random_sample());
            if (inc != INC_MAX)
                random_items += count;
            phase_no++;
        end

        // back to the reset rate, then let everything drain
        load_increment(UNITY[31:0]);
        repeat (4) feed(random_sample());
        wait_quiet();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run: %0d sample requests (%0d phase-only) over %0d increment writes",
                 requests_taken, phase_only_requests, cfg_writes);
        $display("Run: %0d interpolated results checked, %0d mismatches",
                 outputs_checked, mismatches);
        if (mismatches == 0 && interp_due_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
